// ===== rtl/bpm_pkg.sv =====
// Types and constants for the buffer pool frame manager.
// No dependencies.
`default_nettype none
package bpm_pkg;
  localparam int PAGE_W = 31;
  localparam logic [2:0] CMD_FETCH  = 3'd0;
  localparam logic [2:0] CMD_NEW    = 3'd1;
  localparam logic [2:0] CMD_UNPIN  = 3'd2;
  localparam logic [2:0] CMD_FLUSH  = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ABSENT   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_UNPINNED = 3'd3;
  localparam logic [2:0] ST_PINNED   = 3'd4;
  localparam logic [PAGE_W-1:0] NO_PAGE_ID = '1;
  typedef logic [PAGE_W-1:0] page_t;
  // per-cell update command broadcast to the frame cells
  typedef struct packed {
    logic  load;     // take new page, pins=1, clean
    logic  pin_inc;
    logic  pin_dec;
    logic  set_dirty;
    logic  clr_dirty;
    logic  clear;    // delete
    page_t page;
  } bpm_cell_op_t;
endpackage
`default_nettype wire

// ===== rtl/bpm_if.sv =====
// Valid/ready channel interfaces for the buffer pool manager.
// Depends on bpm_pkg.
`default_nettype none
interface bpm_in_if import bpm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  page_t      page_number;
  logic       mark_dirty;
  modport source (output valid, cmd, page_number, mark_dirty, input ready);
  modport sink (input valid, cmd, page_number, mark_dirty, output ready);
endinterface

interface bpm_out_if import bpm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] frame_index;
  page_t      assigned_page;
  logic       need_read;
  logic       need_init;
  logic       need_write;
  page_t      write_page;
  modport source (output valid, status, frame_index, assigned_page, need_read,
                  need_init, need_write, write_page, input ready);
  modport sink (input valid, status, frame_index, assigned_page, need_read,
                need_init, need_write, write_page, output ready);
endinterface
`default_nettype wire

// ===== rtl/bpm_frame_cell.sv =====
// One frame entry: page, valid, pin count, dirty, with a local page compare.
// Depends on bpm_pkg.
`default_nettype none
module bpm_frame_cell import bpm_pkg::*; #(
  parameter int PIN_BITS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         sel,
  input  wire bpm_cell_op_t op,
  input  wire page_t        lookup_page,
  output logic              hit,
  output page_t             page,
  output logic              valid,
  output logic [PIN_BITS-1:0] pins,
  output logic              dirty
);
  page_t               page_r;
  logic                valid_r, dirty_r;
  logic [PIN_BITS-1:0] pins_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '0;
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      pins_r <= '0;
    end else if (sel) begin
      if (op.load) begin
        page_r <= op.page;
        valid_r <= 1'b1;
        dirty_r <= 1'b0;
        pins_r <= PIN_BITS'(1);
      end else if (op.clear) begin
        page_r <= '0;
        valid_r <= 1'b0;
        dirty_r <= 1'b0;
        pins_r <= '0;
      end else begin
        if (op.pin_inc && pins_r != '1) pins_r <= pins_r + 1'b1;
        if (op.pin_dec) pins_r <= pins_r - 1'b1;
        if (op.set_dirty) dirty_r <= 1'b1;
        if (op.clr_dirty) dirty_r <= 1'b0;
      end
    end
  end

  assign hit   = valid_r && page_r == lookup_page;
  assign page  = page_r;
  assign valid = valid_r;
  assign pins  = pins_r;
  assign dirty = dirty_r;
endmodule
`default_nettype wire

// ===== rtl/bpm_queue_cell.sv =====
// One slot of a shifting ordered list (free FIFO or LRU order).
// Shift pulls the right neighbor in; removal shifts from a marked slot on.
`default_nettype none
module bpm_queue_cell #(
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] rst_val,
  input  wire logic             shift,     // take neighbor's value
  input  wire logic             load,      // take append value
  input  wire logic [IDX_W-1:0] nb_val,
  input  wire logic [IDX_W-1:0] ld_val,
  output logic [IDX_W-1:0]      val
);
  logic [IDX_W-1:0] val_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= rst_val;
    end else if (load) begin
      val_r <= ld_val;
    end else if (shift) begin
      val_r <= nb_val;
    end
  end
  assign val = val_r;
endmodule
`default_nettype wire

// ===== rtl/buffer_pool_lru_frame_manager.sv =====
// Buffer pool frame manager with LRU replacement: top level.
// Depends on bpm_pkg, bpm_if, bpm_frame_cell and bpm_queue_cell.
//
// Usage: commands arrive on the in_ channel (cmd, page_number, mark_dirty)
// and each valid command (0..4) yields one result on the out_ channel;
// codes 5..7 are dropped without a result. A transfer takes place when valid
// and ready are both high at a rising edge of clk.
// Each command has a registered capture at the input transfer, then the
// S_LOOK state, in which all frame cells compare the page in parallel, a
// priority pick forms the result, and the frame cells and the free/LRU cell
// rows update at the same edge that loads the output register. in_ch.ready
// is high only in the idle state, so a new command is not taken while the
// last one is still in S_LOOK.
// While a result waits, the next command is still taken; its update step is
// held, with in_ch.ready low, until the output register frees up, so a
// stalled receiver blocks the input after one further command.
// Reset (rst_n, synchronous, active low) empties all frames, fills the free
// list with frames 0..N-1 in order, clears the LRU list and restarts new
// page numbering at 0. No clearing pass is needed.
`default_nettype none
module buffer_pool_lru_frame_manager import bpm_pkg::*; #(
  parameter int POOL_FRAMES = 16,
  parameter int PIN_BITS    = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  bpm_in_if.sink   in_ch,
  bpm_out_if.source out_ch
);
  localparam int IDX_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int CNT_W = $clog2(POOL_FRAMES + 1);
  localparam logic [1:0] S_IDLE = 2'd0, S_LOOK = 2'd1;

  logic [1:0] state_r;
  logic [2:0] cmd_r;
  page_t      page_r;
  logic       mdirty_r;
  page_t      next_page_r;
  logic [CNT_W-1:0] free_cnt_r, lru_cnt_r;

  // frame cells
  logic [POOL_FRAMES-1:0] hit, fvalid, fdirty, fsel;
  page_t                  fpage [POOL_FRAMES];
  logic [PIN_BITS-1:0]    fpins [POOL_FRAMES];
  bpm_cell_op_t           op;

  // queue rows
  logic [IDX_W-1:0] fq [POOL_FRAMES];
  logic [IDX_W-1:0] lq [POOL_FRAMES];
  logic [POOL_FRAMES-1:0] fq_shift, fq_load, lq_shift, lq_load, lq_match;
  logic [IDX_W-1:0] fq_ld, lq_ld;

  // lookup results
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic             lq_found;
  logic [IDX_W-1:0] lq_pos;

  // result register
  logic       ov_r;
  logic [2:0] st_r;
  logic [3:0] fi_r;
  page_t      ap_r, wp_r;
  logic       rd_r, in_r, wr_r;

  genvar g;
  generate
    for (g = 0; g < POOL_FRAMES; g++) begin : g_cell
      bpm_frame_cell #(.PIN_BITS(PIN_BITS)) u_frame (
        .clk, .rst_n, .sel(fsel[g]), .op, .lookup_page(page_r),
        .hit(hit[g]), .page(fpage[g]), .valid(fvalid[g]), .pins(fpins[g]),
        .dirty(fdirty[g]));
      bpm_queue_cell #(.IDX_W(IDX_W)) u_free (
        .clk, .rst_n, .rst_val(IDX_W'(g)), .shift(fq_shift[g]),
        .load(fq_load[g]), .nb_val(fq[(g + 1) % POOL_FRAMES]), .ld_val(fq_ld),
        .val(fq[g]));
      bpm_queue_cell #(.IDX_W(IDX_W)) u_lru (
        .clk, .rst_n, .rst_val('0), .shift(lq_shift[g]),
        .load(lq_load[g]), .nb_val(lq[(g + 1) % POOL_FRAMES]), .ld_val(lq_ld),
        .val(lq[g]));
      assign lq_match[g] = (CNT_W'(g) < lru_cnt_r) && lq[g] == hit_idx;
    end
  endgenerate

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = POOL_FRAMES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
    lq_found = 1'b0;
    lq_pos = '0;
    for (int i = POOL_FRAMES - 1; i >= 0; i--) begin
      if (lq_match[i]) begin
        lq_found = 1'b1;
        lq_pos = IDX_W'(i);
      end
    end
  end

  // decision, computed in S_LOOK and applied at the same edge
  logic             take_free, take_lru, do_load, do_hit_pin, do_unpin;
  logic             do_flush, do_del, lru_rm, lru_app;
  logic [IDX_W-1:0] tgt;
  logic [2:0]       st_nxt;
  logic             rd_nxt, in_nxt, wr_nxt;
  page_t            wp_nxt, ap_nxt;
  logic [PIN_BITS-1:0] hpins;

  always_comb begin
    take_free = 1'b0; take_lru = 1'b0; do_load = 1'b0; do_hit_pin = 1'b0;
    do_unpin = 1'b0; do_flush = 1'b0; do_del = 1'b0; lru_rm = 1'b0;
    lru_app = 1'b0;
    tgt = hit_idx;
    st_nxt = ST_OK;
    rd_nxt = 1'b0; in_nxt = 1'b0; wr_nxt = 1'b0; wp_nxt = '0;
    ap_nxt = (cmd_r == CMD_NEW) ? next_page_r : page_r;
    hpins = fpins[hit_idx];
    if (cmd_r == CMD_FETCH && hit_any) begin
      do_hit_pin = 1'b1;
      lru_rm = lq_found;
    end else if (cmd_r == CMD_FETCH || cmd_r == CMD_NEW) begin
      if (free_cnt_r != '0) begin
        take_free = 1'b1;
        tgt = fq[0];
      end else if (lru_cnt_r != '0) begin
        take_lru = 1'b1;
        tgt = lq[0];
      end else begin
        st_nxt = ST_FULL;
      end
      if (take_free || take_lru) begin
        do_load = 1'b1;
        if (fvalid[tgt] && fdirty[tgt]) begin
          wr_nxt = 1'b1;
          wp_nxt = fpage[tgt];
        end
        rd_nxt = (cmd_r == CMD_FETCH);
        in_nxt = (cmd_r == CMD_NEW);
      end
    end else if (!hit_any) begin
      st_nxt = ST_ABSENT;
    end else if (cmd_r == CMD_UNPIN) begin
      if (hpins == '0) begin
        st_nxt = ST_UNPINNED;
      end else begin
        do_unpin = 1'b1;
        lru_app = (hpins == PIN_BITS'(1)) && !lq_found &&
                  lru_cnt_r < CNT_W'(POOL_FRAMES);
      end
    end else if (cmd_r == CMD_FLUSH) begin
      do_flush = 1'b1;
      wr_nxt = fdirty[hit_idx];
      wp_nxt = fdirty[hit_idx] ? page_r : '0;
    end else begin
      if (hpins != '0) begin
        st_nxt = ST_PINNED;
      end else begin
        do_del = 1'b1;
        lru_rm = lq_found;
        wr_nxt = fdirty[hit_idx];
        wp_nxt = fdirty[hit_idx] ? page_r : '0;
      end
    end
  end

  logic in_look;
  logic upd;
  assign in_look = (state_r == S_LOOK);
  // update step runs only when the output register can take the result
  assign upd = in_look && (!ov_r || out_ch.ready);

  always_comb begin
    op.load      = do_load;
    op.pin_inc   = do_hit_pin;
    op.pin_dec   = do_unpin;
    op.set_dirty = do_unpin && mdirty_r;
    op.clr_dirty = do_flush;
    op.clear     = do_del;
    op.page      = ap_nxt;
    fsel = '0;
    if (upd) fsel[tgt] = 1'b1;
    fq_shift = '0; fq_load = '0; lq_shift = '0; lq_load = '0;
    fq_ld = hit_idx;
    lq_ld = hit_idx;
    for (int i = 0; i < POOL_FRAMES; i++) begin
      if (upd) begin
        if (take_free && i < POOL_FRAMES - 1) fq_shift[i] = 1'b1;
        if (do_del && free_cnt_r < CNT_W'(POOL_FRAMES) &&
            CNT_W'(i) == free_cnt_r) fq_load[i] = 1'b1;
        if (take_lru && i < POOL_FRAMES - 1) lq_shift[i] = 1'b1;
        if (lru_rm && IDX_W'(i) >= lq_pos && i < POOL_FRAMES - 1)
          lq_shift[i] = 1'b1;
        if (lru_app && CNT_W'(i) == lru_cnt_r) lq_load[i] = 1'b1;
      end
    end
  end

  // a new command enters only in the idle state
  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      next_page_r <= '0;
      free_cnt_r <= CNT_W'(POOL_FRAMES);
      lru_cnt_r <= '0;
    end else begin
      if (upd) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.cmd <= CMD_DELETE) begin
            cmd_r <= in_ch.cmd;
            page_r <= in_ch.page_number;
            mdirty_r <= in_ch.mark_dirty;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (upd) begin
            st_r <= st_nxt;
            fi_r <= (st_nxt == ST_ABSENT || st_nxt == ST_FULL) ? 4'd0 : 4'(tgt);
            ap_r <= ap_nxt;
            rd_r <= rd_nxt;
            in_r <= in_nxt;
            wr_r <= wr_nxt;
            wp_r <= wp_nxt;
            if (take_free) free_cnt_r <= free_cnt_r - 1'b1;
            else if (do_del && free_cnt_r < CNT_W'(POOL_FRAMES))
              free_cnt_r <= free_cnt_r + 1'b1;
            if (take_lru || lru_rm) lru_cnt_r <= lru_cnt_r - 1'b1;
            else if (lru_app) lru_cnt_r <= lru_cnt_r + 1'b1;
            if (do_load && cmd_r == CMD_NEW) next_page_r <= next_page_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // cell updates are gated by upd, so they hold while stalled
  assign out_ch.valid         = ov_r;
  assign out_ch.status        = st_r;
  assign out_ch.frame_index   = fi_r;
  assign out_ch.assigned_page = ap_r;
  assign out_ch.need_read     = rd_r;
  assign out_ch.need_init     = in_r;
  assign out_ch.need_write    = wr_r;
  assign out_ch.write_page    = wp_r;
endmodule
`default_nettype wire
